// ===== rtl/knp_pkg.sv =====
`default_nettype none

package knp_pkg;

  // Width of a squared distance; larger values saturate to all ones.
  localparam int unsigned DIST_W = 52;

  // Widths of the configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MAX_NB_W   = 6;
  localparam int unsigned VOX_W      = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NEIGHBORS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOXEL_POINTS = 1'd1;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_CAND   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } knp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIST = 4'b0010,
    ST_INS  = 4'b0100,
    ST_EMIT = 4'b1000
  } knp_state_e;

  // Per-cell command from the controller.
  typedef struct packed {
    logic clr;   // drop the cell's point (new query)
    logic ins;   // cell lies in the insertion window
    logic rot;   // rotate one place toward cell 0
    logic wrap;  // this cell is the tail and takes cell 0's point
  } knp_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/knp_dist.sv =====
`default_nettype none

module knp_dist
  import knp_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  go_i,
  input  wire logic [COORD_BITS-1:0] x_i,
  input  wire logic [COORD_BITS-1:0] y_i,
  input  wire logic [COORD_BITS-1:0] z_i,
  input  wire logic [COORD_BITS-1:0] qx_i,
  input  wire logic [COORD_BITS-1:0] qy_i,
  input  wire logic [COORD_BITS-1:0] qz_i,
  output logic                       done_o,
  output logic [DIST_W-1:0]          dist_o
);

  localparam int unsigned SQ_W  = 2 * COORD_BITS;
  localparam int unsigned SUM_W = SQ_W + 2;
  localparam int unsigned EXT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  logic [2:0]            vld_q;
  logic [COORD_BITS-1:0] ax_d, ay_d, az_d;
  logic [COORD_BITS-1:0] ax_q, ay_q, az_q;
  logic [SQ_W-1:0]       sqx_q, sqy_q, sqz_q;
  logic [EXT_W-1:0]      sum_w;
  logic [DIST_W-1:0]     dist_d, dist_q;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    if (d[COORD_BITS]) begin
      d = ~d + 1'b1;
    end
    return d[COORD_BITS-1:0];
  endfunction

  always_comb begin
    ax_d = abs_diff(x_i, qx_i);
    ay_d = abs_diff(y_i, qy_i);
    az_d = abs_diff(z_i, qz_i);
  end

  always_comb begin
    sum_w = EXT_W'(SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q));
    if (sum_w > EXT_W'({DIST_W{1'b1}})) begin
      dist_d = {DIST_W{1'b1}};
    end else begin
      dist_d = sum_w[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], go_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      az_q <= az_d;
    end
    if (vld_q[0]) begin
      sqx_q <= SQ_W'(ax_q) * SQ_W'(ax_q);
      sqy_q <= SQ_W'(ay_q) * SQ_W'(ay_q);
      sqz_q <= SQ_W'(az_q) * SQ_W'(az_q);
    end
    if (vld_q[1]) begin
      dist_q <= dist_d;
    end
  end

  assign done_o = vld_q[2];
  assign dist_o = dist_q;

endmodule

`default_nettype wire

// ===== rtl/knp_cell.sv =====
`default_nettype none

module knp_cell
  import knp_pkg::*;
#(
  parameter int unsigned DATA_W = 124
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire knp_ctl_t          ctl_i,
  input  wire logic [DATA_W-1:0] new_i,
  input  wire logic              ins_left_i,
  input  wire logic [DATA_W-1:0] left_i,
  input  wire logic [DATA_W-1:0] right_i,
  input  wire logic [DATA_W-1:0] head_i,
  output logic                   ins_o,
  output logic [DATA_W-1:0]      data_o
);

  logic              valid_d, valid_q;
  logic [DATA_W-1:0] data_d, data_q;
  logic              take_w;

  // The new point goes at or before this cell when the cell is empty or
  // strictly farther; equal distances keep the older point first.
  assign ins_o  = !valid_q || (data_q[DIST_W-1:0] > new_i[DIST_W-1:0]);
  assign take_w = ctl_i.ins && ins_o;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctl_i.clr) begin
      valid_d = 1'b0;
    end else if (take_w) begin
      valid_d = 1'b1;
      data_d  = ins_left_i ? left_i : new_i;
    end else if (ctl_i.rot) begin
      data_d = ctl_i.wrap ? head_i : right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/k_nearest_point_selector_top.sv =====
// Start, ignored-opcode and filtered-candidate transfers leave the block idle. A candidate
// that passes the voxel filter goes through the transfer, the 3-stage distance unit and the insertion.
// Finish with N kept points keeps the block busy while it emits them and gives N results back to
// back, each registered from cell 0 in the emit state; an empty finish gives one result
// in the cycle right after the transfer. The receiver cannot stall: each result lasts one cycle.
// Reset clears the query to zero, empties the store and loads the register defaults.
`default_nettype none

module k_nearest_point_selector_top
  import knp_pkg::*;
#(
  parameter int unsigned MAX_KEPT   = 32,
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration writes.
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Command channel.
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [1:0]            op_i,
  input  wire logic [COORD_BITS-1:0] x_i,
  input  wire logic [COORD_BITS-1:0] y_i,
  input  wire logic [COORD_BITS-1:0] z_i,
  input  wire logic [VOX_W-1:0]      voxel_count_i,
  // Result channel.
  output logic                       res_valid_o,
  output logic [COORD_BITS-1:0]      near_x_o,
  output logic [COORD_BITS-1:0]      near_y_o,
  output logic [COORD_BITS-1:0]      near_z_o,
  output logic [DIST_W-1:0]          dist_sq_o,
  output logic                       empty_res_o,
  output logic                       last_o
);

  // Each cell stores {x, y, z, dist}, with the distance in the low bits.
  localparam int unsigned DATA_W = 3 * COORD_BITS + DIST_W;
  // The kept count must be able to hold MAX_KEPT itself.
  localparam int unsigned KW     = $clog2(MAX_KEPT + 1);
  localparam int unsigned CMP_W  = (KW > MAX_NB_W) ? KW : MAX_NB_W;

  knp_state_e state_d, state_q;
  knp_op_e    op_w;

  logic [MAX_NB_W-1:0]   max_nb_q;
  logic [VOX_W-1:0]      min_vox_q;
  logic [COORD_BITS-1:0] qx_q, qy_q, qz_q;
  logic [COORD_BITS-1:0] cand_x_q, cand_y_q, cand_z_q;
  logic [KW-1:0]         kept_d, kept_q;
  logic [KW-1:0]         emit_cnt_d, emit_cnt_q, emit_nxt_w;

  logic                  accept_w;
  logic                  go_dist_w;
  logic                  dist_done_w;
  logic [DIST_W-1:0]     dist_w;
  logic [CMP_W-1:0]      mn_ext_w, lim_w;
  logic                  kept_lt_lim_w;
  logic                  tail_ins_w;
  logic                  ins_go_w;
  logic                  emit_last_w;

  logic [DATA_W-1:0]     new_pt_w;
  logic [MAX_KEPT-1:0]   ins_w;
  logic [DATA_W-1:0]     cell_data_w [MAX_KEPT];
  knp_ctl_t              cell_ctl_w [MAX_KEPT];

  logic                  res_valid_q, empty_q, last_q;
  logic [DATA_W-1:0]     res_pt_q;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept_w = start_i && !busy_o;
  assign op_w     = knp_op_e'(op_i);

  // A candidate whose voxel holds too few points is dropped right at the transfer.
  assign go_dist_w = accept_w && (op_w == OP_CAND) && (voxel_count_i >= min_vox_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_nb_q  <= MAX_NB_W'(20);
      min_vox_q <= VOX_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_NEIGHBORS:    max_nb_q  <= cfg_wdata_i[MAX_NB_W-1:0];
        CFG_MIN_VOXEL_POINTS: min_vox_q <= cfg_wdata_i[VOX_W-1:0];
        default: ;
      endcase
    end
  end

  // Query point; the candidate point is held while its distance is computed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0;
      qy_q <= '0;
      qz_q <= '0;
    end else if (accept_w && (op_w == OP_START)) begin
      qx_q <= x_i;
      qy_q <= y_i;
      qz_q <= z_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_dist_w) begin
      cand_x_q <= x_i;
      cand_y_q <= y_i;
      cand_z_q <= z_i;
    end
  end

  knp_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .go_i  (go_dist_w),
    .x_i   (x_i),
    .y_i   (y_i),
    .z_i   (z_i),
    .qx_i  (qx_q),
    .qy_i  (qy_q),
    .qz_i  (qz_q),
    .done_o(dist_done_w),
    .dist_o(dist_w)
  );

  assign new_pt_w = {cand_x_q, cand_y_q, cand_z_q, dist_w};

  // The active limit is the register value, capped at the chain length.
  assign mn_ext_w      = CMP_W'(max_nb_q);
  assign lim_w         = (mn_ext_w > CMP_W'(MAX_KEPT)) ? CMP_W'(MAX_KEPT) : mn_ext_w;
  assign kept_lt_lim_w = (CMP_W'(kept_q) < lim_w);

  // When the store is full, the candidate only goes in if the tail cell is strictly
  // farther; the tail point then falls off the end of the shifted window.
  always_comb begin
    tail_ins_w = 1'b0;
    for (int i = 0; i < MAX_KEPT; i++) begin
      if (KW'(i + 1) == kept_q) begin
        tail_ins_w = ins_w[i];
      end
    end
  end

  assign ins_go_w = (state_q == ST_INS) && (lim_w != '0) && (kept_lt_lim_w || tail_ins_w);

  assign emit_nxt_w  = emit_cnt_q + KW'(1);
  assign emit_last_w = (emit_nxt_w == kept_q);

  // Per-cell commands. The insertion window reaches one cell past the kept points while
  // there is room, and ends at the tail cell once full. During a finish run the kept
  // points rotate toward cell 0, the tail taking cell 0's point, so that after a full
  // run the store is back in its original order.
  always_comb begin
    for (int i = 0; i < MAX_KEPT; i++) begin
      cell_ctl_w[i].clr  = accept_w && (op_w == OP_START);
      cell_ctl_w[i].ins  = ins_go_w &&
                           (kept_lt_lim_w ? (KW'(i) <= kept_q) : (KW'(i) < kept_q));
      cell_ctl_w[i].rot  = (state_q == ST_EMIT) && (KW'(i) < kept_q);
      cell_ctl_w[i].wrap = (KW'(i + 1) == kept_q);
    end
  end

  for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
    logic              ins_left_w;
    logic [DATA_W-1:0] left_w, right_w;

    if (g == 0) begin : g_first
      assign ins_left_w = 1'b0;
      assign left_w     = '0;
    end else begin : g_inner
      assign ins_left_w = ins_w[g-1];
      assign left_w     = cell_data_w[g-1];
    end

    if (g == MAX_KEPT - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid
      assign right_w = cell_data_w[g+1];
    end

    knp_cell #(
      .DATA_W(DATA_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (cell_ctl_w[g]),
      .new_i     (new_pt_w),
      .ins_left_i(ins_left_w),
      .left_i    (left_w),
      .right_i   (right_w),
      .head_i    (cell_data_w[0]),
      .ins_o     (ins_w[g]),
      .data_o    (cell_data_w[g])
    );
  end

  // Sequencer and kept count.
  always_comb begin
    state_d    = state_q;
    kept_d     = kept_q;
    emit_cnt_d = emit_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          case (op_w)
            OP_START: kept_d = '0;
            OP_CAND: begin
              if (go_dist_w) begin
                state_d = ST_DIST;
              end
            end
            OP_FINISH: begin
              if (kept_q != '0) begin
                state_d    = ST_EMIT;
                emit_cnt_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIST: begin
        if (dist_done_w) begin
          state_d = ST_INS;
        end
      end
      ST_INS: begin
        if (ins_go_w && kept_lt_lim_w) begin
          kept_d = kept_q + KW'(1);
        end
        state_d = ST_IDLE;
      end
      ST_EMIT: begin
        emit_cnt_d = emit_nxt_w;
        if (emit_last_w) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      kept_q     <= '0;
      emit_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      kept_q     <= kept_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  // Result register. Each emit cycle captures cell 0 before the chain rotates; an empty
  // finish gives a single zero result flagged as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == ST_EMIT) ||
                     (accept_w && (op_w == OP_FINISH) && (kept_q == '0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT) begin
      res_pt_q <= cell_data_w[0];
      empty_q  <= 1'b0;
      last_q   <= emit_last_w;
    end else begin
      res_pt_q <= '0;
      empty_q  <= 1'b1;
      last_q   <= 1'b1;
    end
  end

  assign res_valid_o = res_valid_q;
  assign near_x_o    = res_pt_q[DATA_W-1 -: COORD_BITS];
  assign near_y_o    = res_pt_q[DATA_W-1-COORD_BITS -: COORD_BITS];
  assign near_z_o    = res_pt_q[DIST_W +: COORD_BITS];
  assign dist_sq_o   = res_pt_q[DIST_W-1:0];
  assign empty_res_o = empty_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire
